// ===== rtl/bpc_pkg.sv =====
`timescale 1ns / 1ps
package bpc_pkg;

  localparam int unsigned NODE_W = 5;
  localparam int unsigned WGT_W  = 16;
  localparam int unsigned COST_W = 22;
  localparam int unsigned EST_W  = 6;
  localparam logic [COST_W-1:0] COST_MAX = 22'h3FFFFF;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    K_TRACE  = 2'd0,
    K_PATH   = 2'd1,
    K_NOPATH = 2'd2,
    K_FULL   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE, S_FULL, S_NOPATH, S_DEQ, S_DEQ2, S_SRD, S_SEV,
    S_WALK, S_WALK2, S_CRD, S_CEV, S_POP, S_POP2
  } state_e;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] tgt;
    logic [WGT_W-1:0]  cost;
  } edge_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [EST_W-1:0]  lvl;
  } qent_t;

endpackage

// ===== rtl/bpc_edge_store.sv =====
`timescale 1ns / 1ps
module bpc_edge_store import bpc_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  edge_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output edge_t         rdata_o
);

  edge_t mem [DEPTH];
  edge_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bfs_path_with_cost.sv =====
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                              | tuser | tlast
// s_axis  | in  | from_node[4:0] to_node[9:5] edge_weight[25:10] | op    | -
// m_axis  | out | node[4:0] total_cost[26:5] branch[32:27]       | kind  | last
//         |     | depth[38:33]                                    |       |
// Load, clear and unused op are handled in the idle state; a full store adds one word.
// A query scans the single read port of the edge store once for every dequeued node,
// and again for each path hop cost lookup.
// s_axis_tready is high only when idle. A stalled output word holds the sequencer.
// rst_ni clears control state only; no clearing pass.
module bfs_path_with_cost import bpc_pkg::*; #(
  parameter int unsigned NODES     = 32,
  parameter int unsigned MAX_EDGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // from_node, to_node, edge_weight
  input  logic [1:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // node, total_cost, branch_estimate, depth_estimate
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast
);

  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);
  localparam int unsigned LW = $clog2(NODES + 1);

  logic [NODE_W-1:0] in_from, in_to;
  logic [WGT_W-1:0]  in_wgt;
  op_e               in_op;
  assign in_from = s_axis_tdata[4:0];
  assign in_to   = s_axis_tdata[9:5];
  assign in_wgt  = s_axis_tdata[25:10];
  assign in_op   = op_e'(s_axis_tuser);

  state_e state_q, state_d;
  logic [CW-1:0]     ecnt_q, ecnt_d;
  logic [NODE_W-1:0] s_q, s_d, e_q, e_d, u_q, u_d, at_q, at_d, prev_q, prev_d;
  logic [LW-1:0]     head_q, head_d, tail_q, tail_d, len_q, len_d;
  logic [CW-1:0]     j_q, j_d;
  logic [EST_W-1:0]  ulvl_q, ulvl_d, kids_q, kids_d, maxk_q, maxk_d, dp_q, dp_d;
  logic [COST_W-1:0] cost_q, cost_d;
  logic [NODES-1:0]  vis_q;

  // output register
  logic              ov_q;
  kind_e             okind_q;
  logic [NODE_W-1:0] onode_q;
  logic [COST_W-1:0] ocost_q;
  logic [EST_W-1:0]  obr_q, odp_q;
  logic              olast_q;

  logic              emit, o_last;
  kind_e             o_kind;
  logic [NODE_W-1:0] o_node;
  logic [COST_W-1:0] o_cost;
  logic [EST_W-1:0]  o_br, o_dp;
  logic              slot_free;
  assign slot_free = !ov_q || m_axis_tready;

  // edge store
  logic  e_we, e_re;
  edge_t e_wdata, e_rd;
  bpc_edge_store #(.DEPTH(MAX_EDGES), .AW(EW)) u_edges (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (ecnt_q[EW-1:0]),
    .wdata_i (e_wdata),
    .re_i    (e_re),
    .raddr_i (j_q[EW-1:0]),
    .rdata_o (e_rd)
  );

  // per-query memories
  qent_t             queue_mem [NODES];
  logic [NODE_W-1:0] parent_mem [NODES];
  logic [NODE_W-1:0] stack_mem [NODES];
  qent_t             q_rd_q;
  logic [NODE_W-1:0] p_rd_q, k_rd_q;
  logic              q_we, p_we, k_we;
  logic [NW-1:0]     q_waddr, p_waddr, k_waddr;
  qent_t             q_wdata;
  logic [NODE_W-1:0] p_wdata, k_wdata;
  logic [LW-1:0]     len_m1;
  assign len_m1 = len_q - LW'(1);

  always_ff @(posedge clk_i) begin
    if (q_we) queue_mem[q_waddr] <= q_wdata;
    if (p_we) parent_mem[p_waddr] <= p_wdata;
    if (k_we) stack_mem[k_waddr] <= k_wdata;
    if (state_q == S_DEQ) q_rd_q <= queue_mem[head_q[NW-1:0]];
    if (state_q == S_WALK) p_rd_q <= parent_mem[NW'(at_q)];
    if (state_q == S_POP) k_rd_q <= stack_mem[len_m1[NW-1:0]];
  end

  // visited marks
  logic          vis_clr, vis_set;
  logic [NW-1:0] vis_idx;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= '0;
    end else if (vis_clr) begin
      vis_q <= NODES'(1) << vis_idx;
    end else if (vis_set) begin
      vis_q[vis_idx] <= 1'b1;
    end
  end

  logic                hit_src, tgt_ok;
  logic [COST_W:0]     csum;
  assign hit_src = (e_rd.src == u_q);
  assign tgt_ok  = (32'(e_rd.tgt) < NODES) && !vis_q[NW'(e_rd.tgt)];
  assign csum    = (COST_W+1)'(cost_q) + (COST_W+1)'(e_rd.cost);

  always_comb begin
    state_d = state_q;
    ecnt_d = ecnt_q; s_d = s_q; e_d = e_q; u_d = u_q; at_d = at_q; prev_d = prev_q;
    head_d = head_q; tail_d = tail_q; len_d = len_q; j_d = j_q;
    ulvl_d = ulvl_q; kids_d = kids_q; maxk_d = maxk_q; dp_d = dp_q; cost_d = cost_q;
    emit = 1'b0; o_kind = K_TRACE; o_node = '0; o_cost = '0; o_br = '0; o_dp = '0;
    o_last = 1'b0;
    e_we = 1'b0; e_re = 1'b0;
    e_wdata = '{src: in_from, tgt: in_to, cost: in_wgt};
    q_we = 1'b0; q_waddr = tail_q[NW-1:0]; q_wdata = '{node: e_rd.tgt, lvl: ulvl_q + 6'd1};
    p_we = 1'b0; p_waddr = NW'(e_rd.tgt); p_wdata = u_q;
    k_we = 1'b0; k_waddr = len_q[NW-1:0]; k_wdata = p_rd_q;
    vis_clr = 1'b0; vis_set = 1'b0; vis_idx = NW'(e_rd.tgt);
    s_axis_tready = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (in_op)
            OP_LOAD: begin
              if (32'(in_from) < NODES && 32'(in_to) < NODES) begin
                if (32'(ecnt_q) >= MAX_EDGES) begin
                  state_d = S_FULL;
                end else begin
                  e_we = 1'b1;
                  ecnt_d = ecnt_q + CW'(1);
                end
              end
            end
            OP_CLEAR: ecnt_d = '0;
            OP_QUERY: begin
              s_d = in_from;
              e_d = in_to;
              if (32'(in_from) >= NODES || 32'(in_to) >= NODES) begin
                state_d = S_NOPATH;
              end else begin
                vis_clr = 1'b1;
                vis_idx = NW'(in_from);
                p_we = 1'b1; p_waddr = NW'(in_from); p_wdata = in_from;
                q_we = 1'b1; q_waddr = '0; q_wdata = '{node: in_from, lvl: '0};
                head_d = '0;
                tail_d = LW'(1);
                maxk_d = '0;
                state_d = S_DEQ;
              end
            end
            OP_NONE: ;
            default: ;
          endcase
        end
      end
      S_FULL: begin
        if (slot_free) begin
          emit = 1'b1; o_kind = K_FULL; o_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_NOPATH: begin
        if (slot_free) begin
          emit = 1'b1; o_kind = K_NOPATH; o_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DEQ: begin
        if (head_q == tail_q) begin
          state_d = S_NOPATH;
        end else begin
          head_d = head_q + LW'(1);
          state_d = S_DEQ2;
        end
      end
      S_DEQ2: begin
        if (slot_free) begin
          emit = 1'b1; o_kind = K_TRACE; o_node = q_rd_q.node;
          u_d = q_rd_q.node;
          ulvl_d = q_rd_q.lvl;
          if (q_rd_q.node == e_q) begin
            dp_d = (q_rd_q.lvl == '0) ? '0 : q_rd_q.lvl + 6'd1;
            at_d = e_q;
            k_we = 1'b1; k_waddr = '0; k_wdata = e_q;
            len_d = LW'(1);
            cost_d = '0;
            state_d = S_WALK;
          end else begin
            kids_d = '0;
            j_d = '0;
            state_d = S_SRD;
          end
        end
      end
      S_SRD: begin
        if (j_q == ecnt_q) begin
          if (kids_q > maxk_q) maxk_d = kids_q;
          state_d = S_DEQ;
        end else begin
          e_re = 1'b1;
          state_d = S_SEV;
        end
      end
      S_SEV: begin
        if (hit_src && tgt_ok) begin
          vis_set = 1'b1;
          p_we = 1'b1;
          q_we = 1'b1;
          tail_d = tail_q + LW'(1);
          kids_d = kids_q + 6'd1;
        end
        j_d = j_q + CW'(1);
        state_d = S_SRD;
      end
      S_WALK: begin
        if (at_q == s_q || 32'(len_q) >= NODES) begin
          state_d = S_POP;
        end else begin
          state_d = S_WALK2;
        end
      end
      S_WALK2: begin
        k_we = 1'b1;
        len_d = len_q + LW'(1);
        prev_d = at_q;
        at_d = p_rd_q;
        j_d = '0;
        state_d = S_CRD;
      end
      S_CRD: begin
        if (j_q == ecnt_q) begin
          state_d = S_WALK;
        end else begin
          e_re = 1'b1;
          state_d = S_CEV;
        end
      end
      S_CEV: begin
        // first matching edge for hop at -> prev
        if (e_rd.src == at_q && e_rd.tgt == prev_q) begin
          cost_d = (csum > (COST_W+1)'(COST_MAX)) ? COST_MAX : csum[COST_W-1:0];
          state_d = S_WALK;
        end else begin
          j_d = j_q + CW'(1);
          state_d = S_CRD;
        end
      end
      S_POP: begin
        len_d = len_m1;
        state_d = S_POP2;
      end
      S_POP2: begin
        if (slot_free) begin
          emit = 1'b1; o_kind = K_PATH; o_node = k_rd_q;
          if (len_q == '0) begin
            o_last = 1'b1;
            o_cost = cost_q;
            o_br = (maxk_q == '0) ? '0 : maxk_q + 6'd1;
            o_dp = dp_q;
            state_d = S_IDLE;
          end else begin
            state_d = S_POP;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ecnt_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      len_q   <= '0;
      j_q     <= '0;
      kids_q  <= '0;
      maxk_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ecnt_q  <= ecnt_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      len_q   <= len_d;
      j_q     <= j_d;
      kids_q  <= kids_d;
      maxk_q  <= maxk_d;
      if (emit) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d; e_q <= e_d; u_q <= u_d; at_q <= at_d; prev_q <= prev_d;
    ulvl_q <= ulvl_d; dp_q <= dp_d; cost_q <= cost_d;
    if (emit) begin
      okind_q <= o_kind; onode_q <= o_node; ocost_q <= o_cost;
      obr_q <= o_br; odp_q <= o_dp; olast_q <= o_last;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, odp_q, obr_q, ocost_q, onode_q};
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("queue head passed tail");
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(tail_q) <= NODES) else $error("queue overflow");
  a_edge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ecnt_q) <= MAX_EDGES) else $error("edge count over capacity");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> slot_free) else $error("output word overwritten");

endmodule

// ===== tb/bfs_path_with_cost_tb.sv =====
`timescale 1ns / 1ps
module bfs_path_with_cost_tb;
  import bpc_pkg::*;

  localparam int NNODE    = 32;
  localparam int EDGE_CAP = 64;
  localparam int LIMIT    = 4000000;

  typedef struct {
    kind_e       kind;
    logic [4:0]  node;
    logic [21:0] cost;
    logic [5:0]  br;
    logic [5:0]  dp;
    bit          last;
  } word_t;

  typedef struct {
    op_e         op;
    logic [4:0]  a;
    logic [4:0]  b;
    logic [15:0] w;
    int          ntyped;  // -1: checked by the predictor
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  bfs_path_with_cost uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // graph copy
  logic [4:0]  g_src [EDGE_CAP];
  logic [4:0]  g_tgt [EDGE_CAP];
  logic [15:0] g_wgt [EDGE_CAP];
  int          g_count = 0;

  word_t expected_words[$];
  word_t bfs_words[$];
  int    fails = 0;
  int    cycles = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;

  function automatic word_t mk(kind_e k, logic [4:0] n, logic [21:0] c, logic [5:0] br,
                               logic [5:0] dp, bit l);
    word_t x;
    x.kind = k; x.node = n; x.cost = c; x.br = br; x.dp = dp; x.last = l;
    return x;
  endfunction

  task automatic bfs_search(input int s, input int e);
    bit visited [NNODE];
    int parent [NNODE];
    int level [NNODE];
    int frontier[$];
    int path[$];
    int u, kids, maxk, at, t, cost, br, dp;
    visited = '{default: 0};
    parent = '{default: 0};
    level = '{default: 0};
    maxk = 0;
    visited[s] = 1;
    parent[s] = s;
    frontier.insert(frontier.size(), s);
    while (frontier.size() > 0) begin
      u = frontier.pop_front();
      kids = 0;
      bfs_words.insert(bfs_words.size(), mk(K_TRACE, 5'(u), '0, '0, '0, 1'b0));
      if (u == e) begin
        at = e;
        path.push_front(at);
        while (at != s && path.size() < NNODE) begin
          at = parent[at];
          path.push_front(at);
        end
        // path now runs start .. end; first matching edge per hop
        cost = 0;
        for (int i = 0; i + 1 < path.size(); i++) begin
          for (int j = 0; j < g_count; j++) begin
            if (g_src[j] == path[i] && g_tgt[j] == path[i+1]) begin
              cost += int'(g_wgt[j]);
              if (cost > int'(COST_MAX)) cost = int'(COST_MAX);
              break;
            end
          end
        end
        br = (maxk == 0) ? 0 : maxk + 1;
        dp = (level[e] == 0) ? 0 : level[e] + 1;
        for (int i = 0; i < path.size(); i++) begin
          if (i == path.size() - 1)
            bfs_words.insert(bfs_words.size(),
                             mk(K_PATH, 5'(path[i]), 22'(cost), 6'(br), 6'(dp), 1'b1));
          else
            bfs_words.insert(bfs_words.size(), mk(K_PATH, 5'(path[i]), '0, '0, '0, 1'b0));
        end
        return;
      end
      for (int j = 0; j < g_count; j++) begin
        if (g_src[j] == u && !visited[g_tgt[j]]) begin
          t = int'(g_tgt[j]);
          visited[t] = 1;
          parent[t] = u;
          level[t] = level[u] + 1;
          frontier.insert(frontier.size(), t);
          kids++;
        end
      end
      if (kids > maxk) maxk = kids;
    end
    bfs_words.insert(bfs_words.size(), mk(K_NOPATH, '0, '0, '0, '0, 1'b1));
  endtask

  // updates the graph copy and leaves the words this item causes in bfs_words
  task automatic graph_step(input op_e op, input logic [4:0] a, input logic [4:0] b,
                            input logic [15:0] w);
    bfs_words.delete();
    case (op)
      OP_LOAD: begin
        if (g_count >= EDGE_CAP) begin
          bfs_words.insert(bfs_words.size(), mk(K_FULL, '0, '0, '0, '0, 1'b1));
        end else begin
          g_src[g_count] = a; g_tgt[g_count] = b; g_wgt[g_count] = w;
          g_count++;
        end
      end
      OP_CLEAR: g_count = 0;
      OP_QUERY: bfs_search(int'(a), int'(b));
      default: ;
    endcase
  endtask

  task automatic send_word(input op_e op, input logic [4:0] a, input logic [4:0] b,
                           input logic [15:0] w);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {6'd0, w, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic push_item(input op_e op, input logic [4:0] a, input logic [4:0] b,
                           input logic [15:0] w);
    send_word(op, a, b, w);
    graph_step(op, a, b, w);
    foreach (bfs_words[i]) expected_words.insert(expected_words.size(), bfs_words[i]);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d node=%0d", $time, m_axis_tuser,
                 m_axis_tdata[4:0]);
        fails++;
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata[4:0] !== want.node ||
            m_axis_tdata[26:5] !== want.cost || m_axis_tdata[32:27] !== want.br ||
            m_axis_tdata[38:33] !== want.dp || m_axis_tlast !== want.last) begin
          $display("%0t: mismatch exp kind=%0d node=%0d cost=%0d br=%0d dp=%0d last=%0d",
                   $time, want.kind, want.node, want.cost, want.br, want.dp, want.last);
          $display("%0t:          got kind=%0d node=%0d cost=%0d br=%0d dp=%0d last=%0d",
                   $time, m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[26:5],
                   m_axis_tdata[32:27], m_axis_tdata[38:33], m_axis_tlast);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  stim_t dir_rows [] = '{
    '{OP_QUERY, 5'd7,  5'd7,  16'h0000, 2},
    '{OP_QUERY, 5'd2,  5'd9,  16'h0000, 2},
    '{OP_NONE,  5'd31, 5'd31, 16'hFFFF, 0},
    '{OP_LOAD,  5'd0,  5'd1,  16'hFFFF, -1},
    '{OP_LOAD,  5'd1,  5'd2,  16'h0000, -1},
    '{OP_LOAD,  5'd0,  5'd2,  16'h0005, -1},
    '{OP_LOAD,  5'd2,  5'd31, 16'h1234, -1},
    '{OP_LOAD,  5'd31, 5'd0,  16'h0007, -1},
    '{OP_LOAD,  5'd1,  5'd3,  16'h0064, -1},
    '{OP_LOAD,  5'd3,  5'd31, 16'hAAAA, -1},
    '{OP_LOAD,  5'd31, 5'd16, 16'h5555, -1},
    '{OP_QUERY, 5'd0,  5'd31, 16'h0000, -1},
    '{OP_QUERY, 5'd0,  5'd16, 16'hFFFF, -1},
    '{OP_QUERY, 5'd16, 5'd0,  16'h0000, -1},
    '{OP_QUERY, 5'd31, 5'd3,  16'h0000, -1},
    '{OP_QUERY, 5'd5,  5'd5,  16'h0000, 2},
    '{OP_CLEAR, 5'd31, 5'd31, 16'hFFFF, 0},
    '{OP_QUERY, 5'd0,  5'd31, 16'h0000, 2},
    '{OP_LOAD,  5'd4,  5'd8,  16'h8000, -1},
    '{OP_QUERY, 5'd4,  5'd8,  16'h0000, -1}
  };

  // hand-read words for the rows that carry a count above
  word_t dir_words [] = '{
    '{K_TRACE, 5'd7, 22'd0, 6'd0, 6'd0, 1'b0},
    '{K_PATH, 5'd7, 22'd0, 6'd0, 6'd0, 1'b1},
    '{K_TRACE, 5'd2, 22'd0, 6'd0, 6'd0, 1'b0},
    '{K_NOPATH, 5'd0, 22'd0, 6'd0, 6'd0, 1'b1},
    '{K_TRACE, 5'd5, 22'd0, 6'd0, 6'd0, 1'b0},
    '{K_PATH, 5'd5, 22'd0, 6'd0, 6'd0, 1'b1},
    '{K_TRACE, 5'd0, 22'd0, 6'd0, 6'd0, 1'b0},
    '{K_NOPATH, 5'd0, 22'd0, 6'd0, 6'd0, 1'b1}
  };

  initial begin
    int wi, n, lo, span, drain;
    logic [4:0] a, b;
    logic [15:0] w;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    wi = 0;
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].w);
      graph_step(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].w);
      if (dir_rows[i].ntyped < 0) begin
        foreach (bfs_words[k]) expected_words.insert(expected_words.size(), bfs_words[k]);
      end else begin
        for (int k = 0; k < dir_rows[i].ntyped; k++)
          expected_words.insert(expected_words.size(), dir_words[wi++]);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      if (ph == 3) begin
        // fill the edge store past its end, then search the full graph
        push_item(OP_CLEAR, '0, '0, '0);
        for (int k = 0; k < EDGE_CAP + 2; k++)
          push_item(OP_LOAD, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                    16'($urandom));
        push_item(OP_QUERY, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), '0);
      end
      n = 0;
      while (n < 45) begin
        if ($urandom_range(0, 99) < 70) begin
          push_item(OP_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom));
          n++;
        end
        lo = $urandom_range(0, 24);
        span = $urandom_range(1, 7);
        repeat ($urandom_range(1, 10)) begin
          a = 5'(lo + $urandom_range(0, span));
          b = 5'(lo + $urandom_range(0, span));
          w = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
          push_item(OP_LOAD, a, b, w);
          n++;
        end
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 9) == 0) begin
            a = 5'($urandom); b = 5'($urandom);
          end else begin
            a = 5'(lo + $urandom_range(0, span));
            b = 5'(lo + $urandom_range(0, span));
          end
          push_item(OP_QUERY, a, b, 16'($urandom));
          n++;
        end
        if ($urandom_range(0, 19) == 0)
          push_item(OP_NONE, 5'($urandom), 5'($urandom), 16'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (expected_words.size() > 0) @(posedge clk_i);
    drain = 0;
    while (drain < 200) begin
      @(posedge clk_i);
      drain++;
    end
    if (fails == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
